// File: src/bfsp_pkg.sv
// Shared types and codes for the shortest-path engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package bfsp_pkg;

  // Input commands. The fourth code has no meaning and is dropped.
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_SOLVE  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOPATH  = 3'd1;
  localparam logic [2:0] ST_NEGCYC  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_BADNODE = 3'd4;

  // Source of the edge table read address.
  typedef enum logic [1:0] {
    EA_SCAN,
    EA_WALK,
    EA_EMIT
  } ea_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_PASS_START,
    S_CHECK_START,
    S_SCAN_RD,
    S_SCAN_DR,
    S_SCAN_RX,
    S_WALK_START,
    S_WALK_CHK,
    S_WALK_PRED,
    S_WALK_EDGE,
    S_EMIT_RD,
    S_EMIT_PB,
    S_EMIT_LD,
    S_EMIT_WAIT
  } state_t;

  typedef struct packed {
    logic       latch_in;
    logic       do_append;
    logic       do_clear;
    logic       init_solve;
    logic       pass_start;
    logic       pass_inc;
    logic       e_clr;
    logic       e_inc;
    logic       edge_re;
    ea_sel_t    edge_sel;
    logic       dist_re;
    logic       relax_commit;
    logic       walk_init;
    logic       pred_re;
    logic       walk_step;
    logic       walk_cur;
    logic       emit_init;
    logic       pbuf_re;
    logic       emit_inc;
    logic       out_load;
    logic       out_path;
    logic       out_idx_load;
    logic [2:0] out_status;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic bad_node;
    logic n_one;
    logic table_full;
    logic no_edges;
    logic edge_last;
    logic relax_hit;
    logic upd_any;
    logic more_passes;
    logic dst_pv;
    logic walk_end;
    logic walk_over;
    logic cnt_zero;
    logic emit_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: src/bfsp_if.sv
// Handshake channel interfaces of the shortest-path engine.
// Input item, result item and configuration write; no dependencies.
interface bfsp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [5:0]  from_node;
  logic [5:0]  to_node;
  logic signed [31:0] weight;
  modport source (output valid, command, from_node, to_node, weight, input ready);
  modport sink   (input valid, command, from_node, to_node, weight, output ready);
endinterface

interface bfsp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] edge_index;
  logic [5:0] edge_start;
  logic [5:0] edge_end;
  logic       last;
  modport source (output valid, status, edge_index, edge_start, edge_end, last,
                  input ready);
  modport sink   (input valid, status, edge_index, edge_start, edge_end, last,
                  output ready);
endinterface

interface bfsp_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] node_count;
  modport source (output valid, node_count, input ready);
  modport sink   (input valid, node_count, output ready);
endinterface

// File: src/bfsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end
endmodule

// File: src/bfsp_dp.sv
// Datapath of the shortest-path engine: edge table, node tables, counters
// and the result register. Depends on bfsp_pkg and bfsp_ram.
module bfsp_dp #(
  parameter int MAX_NODES  = 64,
  parameter int MAX_EDGES  = 256,
  parameter int DIST_WIDTH = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bfsp_pkg::ctrl_cmd_t  cmd,
  output bfsp_pkg::dp_stat_t   stat,
  input  logic                 cfg_we,
  input  logic [6:0]           cfg_node_count,
  input  logic [1:0]           in_command,
  input  logic [5:0]           in_from_node,
  input  logic [5:0]           in_to_node,
  input  logic signed [31:0]   in_weight,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [7:0]           out_edge_index,
  output logic [5:0]           out_edge_start,
  output logic [5:0]           out_edge_end,
  output logic                 out_last
);
  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int NCNT_W = $clog2(MAX_NODES + 1);
  localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);
  localparam int IDX_W  = (EIDX_W > 8) ? EIDX_W : 8;
  localparam int EW     = 6 + 6 + 32;
  localparam int SUM_W  = ((DIST_WIDTH > 32) ? DIST_WIDTH : 32) + 1;
  localparam logic signed [SUM_W-1:0] DMAX =
    {{(SUM_W-DIST_WIDTH+1){1'b0}}, {(DIST_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] DMIN = ~DMAX;

  logic [6:0]              node_count_r;
  logic [6:0]              n_eff;
  bfsp_pkg::op_t           op_r;
  logic [5:0]              src_r, dst_r;
  logic signed [31:0]      weight_r;
  logic [ECNT_W-1:0]       eload_r;
  logic [EIDX_W-1:0]       e_idx_r;
  logic [NCNT_W-1:0]       pass_r;
  logic                    upd_r;
  logic [MAX_NODES-1:0]    reached_r, pv_r;
  logic [NODE_W-1:0]       cur_r;
  logic [NCNT_W-1:0]       cnt_r, k_r;

  logic                    out_valid_r;
  logic [2:0]              out_status_r;
  logic [7:0]              out_idx_r;
  logic [5:0]              out_start_r, out_end_r;
  logic                    out_last_r;

  logic [EW-1:0]           edge_q;
  logic [EIDX_W-1:0]       edge_raddr;
  logic [DIST_WIDTH-1:0]   du_q, dv_q;
  logic                    dist_we;
  logic [NODE_W-1:0]       dist_waddr;
  logic [DIST_WIDTH-1:0]   dist_wdata;
  logic [EIDX_W-1:0]       pred_q, pbuf_q;
  logic [NODE_W-1:0]       pbuf_raddr;

  logic [5:0]              eu, ev;
  logic signed [31:0]      ew;
  logic [NODE_W-1:0]       u_i, v_i;
  logic signed [SUM_W-1:0] sum;
  logic signed [DIST_WIDTH-1:0] cand;
  logic                    relax_hit;
  logic                    commit;
  logic [IDX_W-1:0]        pe_ext, eload_ext;

  assign eu = edge_q[EW-1 -: 6];
  assign ev = edge_q[EW-7 -: 6];
  assign ew = edge_q[31:0];
  assign u_i = eu[NODE_W-1:0];
  assign v_i = ev[NODE_W-1:0];

  // Effective node count: zero acts as one, large values clamp.
  always_comb begin
    if (node_count_r == 7'd0) begin
      n_eff = 7'd1;
    end else if (node_count_r > 7'(MAX_NODES)) begin
      n_eff = 7'(MAX_NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  // Saturating candidate distance and the relax decision.
  always_comb begin
    sum = {{(SUM_W-DIST_WIDTH){du_q[DIST_WIDTH-1]}}, du_q}
        + {{(SUM_W-32){ew[31]}}, ew};
    if (sum > DMAX) begin
      cand = DMAX[DIST_WIDTH-1:0];
    end else if (sum < DMIN) begin
      cand = DMIN[DIST_WIDTH-1:0];
    end else begin
      cand = sum[DIST_WIDTH-1:0];
    end
    relax_hit = ({1'b0, eu} < n_eff) && ({1'b0, ev} < n_eff) && reached_r[u_i]
             && (!reached_r[v_i] || (cand < $signed(dv_q)));
  end

  assign commit = cmd.relax_commit && relax_hit;

  always_comb begin
    unique case (cmd.edge_sel)
      bfsp_pkg::EA_WALK: edge_raddr = pred_q;
      bfsp_pkg::EA_EMIT: edge_raddr = pbuf_q;
      default:           edge_raddr = e_idx_r;
    endcase
  end

  assign dist_we    = cmd.init_solve || commit;
  assign dist_waddr = cmd.init_solve ? src_r[NODE_W-1:0] : v_i;
  assign dist_wdata = cmd.init_solve ? '0 : cand;
  assign pbuf_raddr = NODE_W'(cnt_r - k_r - NCNT_W'(1));

  bfsp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk, .we(cmd.do_append), .waddr(eload_r[EIDX_W-1:0]),
    .wdata({src_r, dst_r, weight_r}), .re(cmd.edge_re), .raddr(edge_raddr),
    .rdata(edge_q)
  );

  // Two copies of the distance table give both edge ends in the same cycle.
  bfsp_ram #(.WIDTH(DIST_WIDTH), .DEPTH(MAX_NODES)) u_dist_u_ram (
    .clk, .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .re(cmd.dist_re), .raddr(u_i), .rdata(du_q)
  );
  bfsp_ram #(.WIDTH(DIST_WIDTH), .DEPTH(MAX_NODES)) u_dist_v_ram (
    .clk, .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .re(cmd.dist_re), .raddr(v_i), .rdata(dv_q)
  );

  bfsp_ram #(.WIDTH(EIDX_W), .DEPTH(MAX_NODES)) u_pred_ram (
    .clk, .we(commit), .waddr(v_i), .wdata(e_idx_r),
    .re(cmd.pred_re), .raddr(cur_r), .rdata(pred_q)
  );

  bfsp_ram #(.WIDTH(EIDX_W), .DEPTH(MAX_NODES)) u_pbuf_ram (
    .clk, .we(cmd.walk_step), .waddr(cnt_r[NODE_W-1:0]), .wdata(pred_q),
    .re(cmd.pbuf_re), .raddr(pbuf_raddr), .rdata(pbuf_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 7'(MAX_NODES);
      eload_r      <= '0;
      reached_r    <= '0;
      pv_r         <= '0;
      upd_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_node_count;
      end
      if (cmd.do_append) begin
        eload_r <= eload_r + ECNT_W'(1);
      end else if (cmd.do_clear) begin
        eload_r <= '0;
      end
      if (cmd.init_solve) begin
        // Only the source node starts out reached.
        reached_r <= {{(MAX_NODES-1){1'b0}}, 1'b1} << src_r[NODE_W-1:0];
        pv_r <= '0;
      end else if (commit) begin
        reached_r[v_i] <= 1'b1;
        pv_r[v_i]      <= 1'b1;
      end
      if (cmd.pass_start) begin
        upd_r <= 1'b0;
      end else if (commit) begin
        upd_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign pe_ext    = IDX_W'(pbuf_q);
  assign eload_ext = IDX_W'(eload_r);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r     <= bfsp_pkg::op_t'(in_command);
      src_r    <= in_from_node;
      dst_r    <= in_to_node;
      weight_r <= in_weight;
    end
    if (cmd.init_solve) begin
      pass_r <= '0;
    end else if (cmd.pass_inc) begin
      pass_r <= pass_r + NCNT_W'(1);
    end
    if (cmd.e_clr) begin
      e_idx_r <= '0;
    end else if (cmd.e_inc) begin
      e_idx_r <= e_idx_r + EIDX_W'(1);
    end
    if (cmd.walk_init) begin
      cur_r <= dst_r[NODE_W-1:0];
      cnt_r <= '0;
    end else begin
      if (cmd.walk_step) begin
        cnt_r <= cnt_r + NCNT_W'(1);
      end
      if (cmd.walk_cur) begin
        cur_r <= eu[NODE_W-1:0];
      end
    end
    if (cmd.emit_init) begin
      k_r <= '0;
    end else if (cmd.emit_inc) begin
      k_r <= k_r + NCNT_W'(1);
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_path ? stat.emit_last : 1'b1;
      if (cmd.out_path) begin
        out_idx_r   <= pe_ext[7:0];
        out_start_r <= eu;
        out_end_r   <= ev;
      end else begin
        out_idx_r   <= cmd.out_idx_load ? eload_ext[7:0] : 8'd0;
        out_start_r <= 6'd0;
        out_end_r   <= 6'd0;
      end
    end
  end

  always_comb begin
    stat.op          = op_r;
    stat.bad_node    = ({1'b0, src_r} >= n_eff) || ({1'b0, dst_r} >= n_eff);
    stat.n_one       = (n_eff == 7'd1);
    stat.table_full  = (eload_r == ECNT_W'(MAX_EDGES));
    stat.no_edges    = (eload_r == '0);
    stat.edge_last   = (ECNT_W'(e_idx_r) + ECNT_W'(1) == eload_r);
    stat.relax_hit   = relax_hit;
    stat.upd_any     = upd_r || commit;
    stat.more_passes = (8'(pass_r) + 8'd2 < {1'b0, n_eff});
    stat.dst_pv      = pv_r[dst_r[NODE_W-1:0]];
    stat.walk_end    = (cur_r == src_r[NODE_W-1:0]) || !pv_r[cur_r];
    stat.walk_over   = (8'(cnt_r) + 8'd1 >= {1'b0, n_eff});
    stat.cnt_zero    = (cnt_r == '0);
    stat.emit_last   = (k_r + NCNT_W'(1) == cnt_r);
    stat.out_busy    = out_valid_r;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_edge_index = out_idx_r;
  assign out_edge_start = out_start_r;
  assign out_edge_end   = out_end_r;
  assign out_last       = out_last_r;
endmodule

// File: src/bfsp_ctrl.sv
// Controller state machine of the shortest-path engine.
// Sequences loads, relaxation passes, path walk and emission; uses bfsp_pkg.
module bfsp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bfsp_pkg::dp_stat_t  stat,
  output bfsp_pkg::ctrl_cmd_t cmd
);
  bfsp_pkg::state_t state_r, state_nxt;
  logic check_r, check_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfsp_pkg::S_IDLE;
      check_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      check_r <= check_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    check_nxt = check_r;
    cmd       = '0;
    cmd.edge_sel = bfsp_pkg::EA_SCAN;
    in_ready  = 1'b0;
    unique case (state_r)
      bfsp_pkg::S_IDLE: begin
        in_ready = !stat.out_busy;
        if (in_valid && !stat.out_busy) begin
          cmd.latch_in = 1'b1;
          state_nxt = bfsp_pkg::S_DISPATCH;
        end
      end
      bfsp_pkg::S_DISPATCH: begin
        state_nxt = bfsp_pkg::S_IDLE;
        check_nxt = 1'b0;
        case (stat.op)
          bfsp_pkg::OP_APPEND: begin
            cmd.out_load = 1'b1;
            if (stat.table_full) begin
              cmd.out_status = bfsp_pkg::ST_FULL;
            end else begin
              cmd.do_append    = 1'b1;
              cmd.out_idx_load = 1'b1;
              cmd.out_status   = bfsp_pkg::ST_OK;
            end
          end
          bfsp_pkg::OP_CLEAR: begin
            cmd.do_clear   = 1'b1;
            cmd.out_load   = 1'b1;
            cmd.out_status = bfsp_pkg::ST_OK;
          end
          bfsp_pkg::OP_SOLVE: begin
            if (stat.bad_node) begin
              cmd.out_load   = 1'b1;
              cmd.out_status = bfsp_pkg::ST_BADNODE;
            end else begin
              cmd.init_solve = 1'b1;
              state_nxt = stat.n_one ? bfsp_pkg::S_CHECK_START
                                     : bfsp_pkg::S_PASS_START;
            end
          end
          default: ;
        endcase
      end
      bfsp_pkg::S_PASS_START: begin
        cmd.pass_start = 1'b1;
        cmd.e_clr      = 1'b1;
        state_nxt = stat.no_edges ? bfsp_pkg::S_CHECK_START : bfsp_pkg::S_SCAN_RD;
      end
      bfsp_pkg::S_CHECK_START: begin
        check_nxt = 1'b1;
        cmd.e_clr = 1'b1;
        state_nxt = stat.no_edges ? bfsp_pkg::S_WALK_START : bfsp_pkg::S_SCAN_RD;
      end
      bfsp_pkg::S_SCAN_RD: begin
        cmd.edge_re = 1'b1;
        state_nxt = bfsp_pkg::S_SCAN_DR;
      end
      bfsp_pkg::S_SCAN_DR: begin
        cmd.dist_re = 1'b1;
        state_nxt = bfsp_pkg::S_SCAN_RX;
      end
      bfsp_pkg::S_SCAN_RX: begin
        cmd.e_inc = 1'b1;
        if (check_r) begin
          if (stat.relax_hit) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = bfsp_pkg::ST_NEGCYC;
            state_nxt = bfsp_pkg::S_IDLE;
          end else if (stat.edge_last) begin
            state_nxt = bfsp_pkg::S_WALK_START;
          end else begin
            state_nxt = bfsp_pkg::S_SCAN_RD;
          end
        end else begin
          cmd.relax_commit = 1'b1;
          if (!stat.edge_last) begin
            state_nxt = bfsp_pkg::S_SCAN_RD;
          end else if (stat.upd_any && stat.more_passes) begin
            cmd.pass_inc = 1'b1;
            state_nxt = bfsp_pkg::S_PASS_START;
          end else begin
            state_nxt = bfsp_pkg::S_CHECK_START;
          end
        end
      end
      bfsp_pkg::S_WALK_START: begin
        if (!stat.dst_pv) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = bfsp_pkg::ST_NOPATH;
          state_nxt = bfsp_pkg::S_IDLE;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt = bfsp_pkg::S_WALK_CHK;
        end
      end
      bfsp_pkg::S_WALK_CHK: begin
        if (stat.walk_end) begin
          if (stat.cnt_zero) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = bfsp_pkg::ST_NOPATH;
            state_nxt = bfsp_pkg::S_IDLE;
          end else begin
            cmd.emit_init = 1'b1;
            state_nxt = bfsp_pkg::S_EMIT_RD;
          end
        end else if (stat.walk_over) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = bfsp_pkg::ST_NEGCYC;
          state_nxt = bfsp_pkg::S_IDLE;
        end else begin
          cmd.pred_re = 1'b1;
          state_nxt = bfsp_pkg::S_WALK_PRED;
        end
      end
      bfsp_pkg::S_WALK_PRED: begin
        cmd.walk_step = 1'b1;
        cmd.edge_re   = 1'b1;
        cmd.edge_sel  = bfsp_pkg::EA_WALK;
        state_nxt = bfsp_pkg::S_WALK_EDGE;
      end
      bfsp_pkg::S_WALK_EDGE: begin
        cmd.walk_cur = 1'b1;
        state_nxt = bfsp_pkg::S_WALK_CHK;
      end
      bfsp_pkg::S_EMIT_RD: begin
        cmd.pbuf_re = 1'b1;
        state_nxt = bfsp_pkg::S_EMIT_PB;
      end
      bfsp_pkg::S_EMIT_PB: begin
        cmd.edge_re  = 1'b1;
        cmd.edge_sel = bfsp_pkg::EA_EMIT;
        state_nxt = bfsp_pkg::S_EMIT_LD;
      end
      bfsp_pkg::S_EMIT_LD: begin
        cmd.out_load   = 1'b1;
        cmd.out_path   = 1'b1;
        cmd.out_status = bfsp_pkg::ST_OK;
        state_nxt = bfsp_pkg::S_EMIT_WAIT;
      end
      bfsp_pkg::S_EMIT_WAIT: begin
        if (!stat.out_busy) begin
          if (stat.emit_last) begin
            state_nxt = bfsp_pkg::S_IDLE;
          end else begin
            cmd.emit_inc = 1'b1;
            state_nxt = bfsp_pkg::S_EMIT_RD;
          end
        end
      end
      default: state_nxt = bfsp_pkg::S_IDLE;
    endcase
  end
endmodule

// File: src/bellman_ford_shortest_path.sv
// Top level of the Bellman-Ford shortest-path engine.
// Depends on bfsp_pkg, the channel interfaces, bfsp_ctrl, bfsp_dp and bfsp_ram.
//
// Usage: items arrive on in_if. Command append stores one edge in load order
// and returns one result carrying the edge's index (or table full). Command
// clear empties the edge table and returns one result. Command solve runs
// Bellman-Ford from from_node and returns the path edges to to_node in forward
// order, the last one flagged by last, or one no-path, negative-cycle or
// bad-node result. The fourth command code is dropped without a result.
// cfg_if writes node_count; it is always ready. It must be written only while
// idle; the block does not enforce this. An append or clear result is loaded
// from the dispatch state. A solve does an edge table read, a distance table
// read and the relax compare per edge, for up to node_count-1 passes plus one
// check pass. The path walk does a check, a predecessor read and an edge read
// per path edge; emission a buffer read, an edge read, a result load and a
// wait per result. Only one item is in work at a time; in_if.ready is high
// while the controller is idle and the result register is empty. A stalled
// receiver simply holds the result register, and the sequencer waits for
// each transfer. Reset clears the edge count and sets node_count to MAX_NODES;
// no clearing pass is needed since node tables are rebuilt by every solve.
module bellman_ford_shortest_path #(
  parameter int MAX_NODES  = 64,
  parameter int MAX_EDGES  = 256,
  parameter int DIST_WIDTH = 40
) (
  input  logic         clk,
  input  logic         rst_n,
  bfsp_in_if.sink      in_if,
  bfsp_out_if.source   out_if,
  bfsp_cfg_if.sink     cfg_if
);
  bfsp_pkg::ctrl_cmd_t cmd;
  bfsp_pkg::dp_stat_t  stat;

  // The register write never stalls.
  assign cfg_if.ready = 1'b1;

  bfsp_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .stat, .cmd
  );

  bfsp_dp #(
    .MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .DIST_WIDTH(DIST_WIDTH)
  ) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .cfg_we(cfg_if.valid), .cfg_node_count(cfg_if.node_count),
    .in_command(in_if.command), .in_from_node(in_if.from_node),
    .in_to_node(in_if.to_node), .in_weight(in_if.weight),
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .out_status(out_if.status), .out_edge_index(out_if.edge_index),
    .out_edge_start(out_if.edge_start), .out_edge_end(out_if.edge_end),
    .out_last(out_if.last)
  );
endmodule

// File: verif/testbench.sv
// Self-checking testbench for the bellman_ford_shortest_path engine.
// Depends on bfsp_pkg, the bfsp channel interfaces and the engine's RTL;
// a scoreboard class predicts every result and checks the output transfers.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  class path_scoreboard;
    typedef struct packed {
      logic [2:0] status;
      logic [7:0] edge_index;
      logic [5:0] edge_start;
      logic [5:0] edge_end;
      logic       last;
    } result_t;

    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 256;
    localparam longint DIST_MAX = (64'sd1 <<< 39) - 1;
    localparam longint DIST_MIN = -DIST_MAX - 1;

    logic [6:0]  node_count;
    logic [5:0]  edge_from[MAX_EDGES];
    logic [5:0]  edge_to[MAX_EDGES];
    longint      edge_wt[MAX_EDGES];
    int          edges_loaded;
    longint      node_dist[MAX_NODES];
    bit          reached[MAX_NODES];
    int          pred[MAX_NODES];
    bit          has_pred[MAX_NODES];
    result_t     pending_results[$];
    int          mismatches;

    function new();
      node_count = 7'd64;
      edges_loaded = 0;
      mismatches = 0;
    endfunction

    function void set_node_count(logic [6:0] value);
      node_count = value;
    endfunction

    function int effective_nodes();
      if (node_count < 1) return 1;
      if (node_count > MAX_NODES) return MAX_NODES;
      return int'(node_count);
    endfunction

    function void push(int st, int idx, int s, int e, int lst);
      result_t r;
      r.status = 3'(st);
      r.edge_index = 8'(idx);
      r.edge_start = 6'(s);
      r.edge_end = 6'(e);
      r.last = 1'(lst);
      pending_results = {pending_results, r};
    endfunction

    function longint add_saturated(longint d, longint w);
      if (w > 0 && d > DIST_MAX - w) return DIST_MAX;
      if (w < 0 && d < DIST_MIN - w) return DIST_MIN;
      return d + w;
    endfunction

    // Returns 1 when edge e would lower (or first reach) the distance of its end.
    function bit try_relax(int e, int n, bit commit);
      int     u;
      int     v;
      longint cand;
      u = edge_from[e];
      v = edge_to[e];
      if (u >= n || v >= n || !reached[u]) return 0;
      cand = add_saturated(node_dist[u], edge_wt[e]);
      if (reached[v] && !(cand < node_dist[v])) return 0;
      if (commit) begin
        node_dist[v] = cand;
        reached[v] = 1;
        pred[v] = e;
        has_pred[v] = 1;
      end
      return 1;
    endfunction

    function void predict_solve(int src, int dst);
      int n;
      int cur;
      int cnt;
      int hops[$];
      bit changed;
      n = effective_nodes();
      if (src >= n || dst >= n) begin
        push(bfsp_pkg::ST_BADNODE, 0, 0, 0, 1);
        return;
      end
      for (int i = 0; i < MAX_NODES; i++) begin
        reached[i] = 0;
        has_pred[i] = 0;
      end
      node_dist[src] = 0;
      reached[src] = 1;
      for (int p = 0; p + 1 < n; p++) begin
        changed = 0;
        for (int e = 0; e < edges_loaded; e++)
          if (try_relax(e, n, 1)) changed = 1;
        if (!changed) break;
      end
      for (int e = 0; e < edges_loaded; e++) begin
        if (try_relax(e, n, 0)) begin
          push(bfsp_pkg::ST_NEGCYC, 0, 0, 0, 1);
          return;
        end
      end
      if (!has_pred[dst]) begin
        push(bfsp_pkg::ST_NOPATH, 0, 0, 0, 1);
        return;
      end
      // Walk back along predecessor edges; a walk that is too long means a loop.
      cur = dst;
      cnt = 0;
      while (cur != src && has_pred[cur]) begin
        if (cnt + 1 >= n) begin
          push(bfsp_pkg::ST_NEGCYC, 0, 0, 0, 1);
          return;
        end
        hops.push_front(pred[cur]);
        cnt++;
        cur = edge_from[pred[cur]];
      end
      if (cnt == 0) begin
        push(bfsp_pkg::ST_NOPATH, 0, 0, 0, 1);
        return;
      end
      foreach (hops[k])
        push(bfsp_pkg::ST_OK, hops[k][7:0], edge_from[hops[k]], edge_to[hops[k]],
             k == cnt - 1);
    endfunction

    function void note_input(logic [1:0] cmd, logic [5:0] a, logic [5:0] b,
                             logic signed [31:0] w);
      case (cmd)
        bfsp_pkg::OP_APPEND: begin
          if (edges_loaded >= MAX_EDGES) begin
            push(bfsp_pkg::ST_FULL, 0, 0, 0, 1);
          end else begin
            edge_from[edges_loaded] = a;
            edge_to[edges_loaded] = b;
            edge_wt[edges_loaded] = longint'(w);
            push(bfsp_pkg::ST_OK, edges_loaded[7:0], 0, 0, 1);
            edges_loaded++;
          end
        end
        bfsp_pkg::OP_SOLVE: predict_solve(int'(a), int'(b));
        bfsp_pkg::OP_CLEAR: begin
          edges_loaded = 0;
          push(bfsp_pkg::ST_OK, 0, 0, 0, 1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result %0d/%0d/%0d/%0d/%0d",
                   $realtime, got.status, got.edge_index, got.edge_start,
                   got.edge_end, got.last);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                   $realtime, want.status, want.edge_index, want.edge_start,
                   want.edge_end, want.last, got.status, got.edge_index,
                   got.edge_start, got.edge_end, got.last);
      end
    endfunction
  endclass

  // The fourth command code is reserved and must be dropped by the engine.
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int IDLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bfsp_in_if  in_if();
  bfsp_out_if out_if();
  bfsp_cfg_if cfg_if();

  bellman_ford_shortest_path dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #4 clk = ~clk;

  path_scoreboard scoreboard = new();

  // When calm is set, neither side inserts gaps.
  bit calm = 1'b0;
  bit random_started = 1'b0;
  logic hold_off = 1'b0;
  int hold_cycles = 0;
  int idle_cycles = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one input item and hold it until the engine takes it.
  task automatic send_item(logic [1:0] cmd, logic [5:0] a, logic [5:0] b,
                           logic signed [31:0] w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.command <= cmd;
    in_if.from_node <= a;
    in_if.to_node <= b;
    in_if.weight <= w;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    scoreboard.note_input(cmd, a, b, w);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (scoreboard.pending_results.size() != 0) @(posedge clk);
    // A reserved command may still be in flight with no result to show for it.
    repeat (12) @(posedge clk);
  endtask

  task automatic write_node_count(logic [6:0] value);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.node_count <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    scoreboard.set_node_count(value);
  endtask

  function automatic logic [5:0] pick_node();
    int n;
    n = scoreboard.effective_nodes();
    if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, n - 1));
  endfunction

  function automatic logic signed [31:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 32'($urandom_range(0, 50));
    if (r < 85) return -32'sd1 * 32'($urandom_range(1, 8));
    return $urandom;
  endfunction

  // One random phase: mostly edge loads followed by solves, with noise mixed in.
  task automatic random_phase(int items);
    int done;
    int burst;
    done = 0;
    while (done < items) begin
      if (scoreboard.edges_loaded > 40 || $urandom_range(0, 9) == 0) begin
        send_item(bfsp_pkg::OP_CLEAR, 6'($urandom), 6'($urandom), $urandom);
        done++;
      end
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        send_item(bfsp_pkg::OP_APPEND, pick_node(), pick_node(), pick_weight());
        done++;
      end
      repeat ($urandom_range(1, 3)) begin
        send_item(bfsp_pkg::OP_SOLVE, pick_node(), pick_node(), $urandom);
        done++;
      end
      if ($urandom_range(0, 7) == 0) begin
        send_item(CMD_RESERVED, 6'($urandom), 6'($urandom), $urandom);
      end
    end
  endtask

  // Result side: checks each transfer and stalls at random.
  always @(posedge clk) begin
    if (out_if.valid && out_if.ready)
      scoreboard.check_result({out_if.status, out_if.edge_index, out_if.edge_start,
                               out_if.edge_end, out_if.last});
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_off) begin
      out_if.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      hold_cycles <= pick_gap();
      out_if.ready <= 1'b1;
    end
  end

  // Long receiver hold-off while the sender keeps offering items, so the
  // engine's result register fills and it stops taking input.
  initial begin
    wait (random_started);
    repeat (30) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [6:0] phase_counts[8];
    in_if.valid <= 1'b0;
    in_if.command <= bfsp_pkg::OP_APPEND;
    in_if.from_node <= '0;
    in_if.to_node <= '0;
    in_if.weight <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.node_count <= 7'd64;
    phase_counts = '{7'd64, 7'd8, 7'd1, 7'd0, 7'd127, 7'd20, 7'd2, 7'd5};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset node count of 64.
    send_item(bfsp_pkg::OP_SOLVE, 6'd0, 6'd0, 32'sd0);      // empty table
    send_item(bfsp_pkg::OP_APPEND, 6'd0, 6'd1, 32'sd5);
    send_item(bfsp_pkg::OP_APPEND, 6'd1, 6'd2, -32'sd3);
    send_item(bfsp_pkg::OP_APPEND, 6'd0, 6'd2, 32'sd10);
    send_item(bfsp_pkg::OP_APPEND, 6'd2, 6'd63, 32'sh7FFFFFFF);
    send_item(bfsp_pkg::OP_APPEND, 6'd63, 6'd62, 32'sh7FFFFFFF);
    send_item(bfsp_pkg::OP_APPEND, 6'd62, 6'd61, -32'sh80000000);
    send_item(bfsp_pkg::OP_SOLVE, 6'd0, 6'd2, 32'sd0);      // path through node 1
    send_item(bfsp_pkg::OP_SOLVE, 6'd0, 6'd61, 32'sd0);     // path through extremes
    send_item(bfsp_pkg::OP_SOLVE, 6'd0, 6'd0, 32'sd0);      // target is the source
    send_item(bfsp_pkg::OP_SOLVE, 6'd61, 6'd0, 32'sd0);     // unreachable target
    send_item(CMD_RESERVED, 6'd63, 6'd63, 32'shFFFFFFFF);   // dropped silently
    send_item(bfsp_pkg::OP_APPEND, 6'd3, 6'd4, -32'sd1);
    send_item(bfsp_pkg::OP_APPEND, 6'd4, 6'd3, -32'sd1);
    send_item(bfsp_pkg::OP_SOLVE, 6'd3, 6'd4, 32'sd0);      // negative cycle
    send_item(bfsp_pkg::OP_CLEAR, 6'd0, 6'd0, 32'sd0);
    send_item(bfsp_pkg::OP_SOLVE, 6'd0, 6'd1, 32'sd0);      // cleared table
    send_item(bfsp_pkg::OP_APPEND, 6'd0, 6'd5, 32'sd1);
    write_node_count(7'd4);
    send_item(bfsp_pkg::OP_SOLVE, 6'd0, 6'd5, 32'sd0);      // target out of range
    send_item(bfsp_pkg::OP_SOLVE, 6'd3, 6'd1, 32'sd0);
    send_item(bfsp_pkg::OP_CLEAR, 6'd0, 6'd0, 32'sd0);

    random_started = 1'b1;
    foreach (phase_counts[p]) begin
      write_node_count(phase_counts[p]);
      calm = (p % 3 == 2);
      random_phase(3);
    end
    calm = 1'b0;

    // Fill the edge table past its end, then solve over the full table.
    write_node_count(7'd3);
    repeat (258) send_item(bfsp_pkg::OP_APPEND, pick_node(), pick_node(), pick_weight());
    send_item(bfsp_pkg::OP_SOLVE, 6'd0, 6'd2, 32'sd0);
    send_item(bfsp_pkg::OP_CLEAR, 6'd0, 6'd0, 32'sd0);
    write_node_count(7'd64);
    random_phase(4);

    wait_drained();
    repeat (50) @(posedge clk);
    if (scoreboard.mismatches == 0 && scoreboard.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
